@@ hw/rtl/r3fc_pkg.sv @@
// Shared types, constants and the CRC-24Q byte step for the RTCM3 frame checker.
`default_nettype none

package r3fc_pkg;

  // One byte request from the upstream side.
  typedef struct packed {
    logic [7:0] byte_value;
    logic       last_byte;
  } in_t;

  // One frame verdict for the downstream side.
  typedef struct packed {
    logic        frame_ok;
    logic [11:0] msg_number;
    logic [23:0] crc_value;
  } out_t;

  localparam logic [7:0]  PreambleByte  = 8'hD3;
  localparam logic [7:0]  ReservedMask  = 8'hFC;
  localparam logic [23:0] CrcPoly       = 24'h864CFB;
  localparam logic [10:0] FrameOverhead = 11'd6;
  localparam logic [10:0] MinFrameBytes = 11'd8;
  localparam logic [10:0] CountMax      = 11'd2047;
  localparam logic [9:0]  MinLength     = 10'd2;

  // Byte positions of the header fields within a frame.
  localparam logic [10:0] IdxPreamble = 11'd0;
  localparam logic [10:0] IdxLenHi    = 11'd1;
  localparam logic [10:0] IdxLenLo    = 11'd2;
  localparam logic [10:0] IdxTypeHi   = 11'd3;
  localparam logic [10:0] IdxTypeLo   = 11'd4;

  // Fold one byte into the CRC, MSB first, eight unrolled shift steps.
  function automatic logic [23:0] crc24q_byte(input logic [23:0] crc_in,
                                              input logic [7:0]  data);
    logic [23:0] crc;
    crc = crc_in ^ {data, 16'h0000};
    for (int k = 0; k < 8; k++) begin
      crc = crc[23] ? ({crc[22:0], 1'b0} ^ CrcPoly) : {crc[22:0], 1'b0};
    end
    return crc;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/r3fc_in_stage.sv @@
// Input register that holds one byte request until the frame core takes it.
`default_nettype none

module r3fc_in_stage (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire r3fc_pkg::in_t in_data_i,
  input  wire logic          advance_i,
  output logic               in_stall_o,
  output logic               valid_o,
  output r3fc_pkg::in_t      data_o
);

  logic          valid_q;
  r3fc_pkg::in_t data_q;
  logic          accept;

  // Hold off upstream only while the stored request cannot move on.
  assign in_stall_o = valid_q && !advance_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (accept) begin
      valid_q <= 1'b1;
    end else if (advance_i) begin
      valid_q <= 1'b0;
    end
  end

  // Payload needs no reset; it is qualified by valid_q.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      data_q <= in_data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

@@ hw/rtl/r3fc_frame_core.sv @@
// Per-frame state: header capture, three-byte delay line, running CRC and verdict.
`default_nettype none

module r3fc_frame_core (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          advance_i,
  input  wire r3fc_pkg::in_t item_i,
  output r3fc_pkg::out_t     result_o
);

  logic [23:0] crc_q, crc_d;
  logic [10:0] count_q, count_d;
  logic [7:0]  tail_q [3];
  logic [7:0]  tail_d [3];
  logic [9:0]  len_q, len_d;
  logic [11:0] type_q, type_d;
  logic        hdr_bad_q, hdr_bad_d;
  logic [7:0]  b;
  logic [23:0] expected;
  logic        ok;

  assign b = item_i.byte_value;

  // Next state for the byte at the head of the input register.
  always_comb begin
    hdr_bad_d = hdr_bad_q;
    len_d     = len_q;
    type_d    = type_q;
    unique case (count_q)
      r3fc_pkg::IdxPreamble: begin
        if (b != r3fc_pkg::PreambleByte) hdr_bad_d = 1'b1;
      end
      r3fc_pkg::IdxLenHi: begin
        if ((b & r3fc_pkg::ReservedMask) != 8'h00) hdr_bad_d = 1'b1;
        len_d[9:8] = b[1:0];
      end
      r3fc_pkg::IdxLenLo: begin
        len_d[7:0] = b;
      end
      r3fc_pkg::IdxTypeHi: begin
        type_d[11:4] = b;
      end
      r3fc_pkg::IdxTypeLo: begin
        type_d[3:0] = b[7:4];
      end
      default: begin
      end
    endcase

    // The byte leaving the delay line enters the CRC from the fourth byte on.
    crc_d = (count_q >= r3fc_pkg::IdxTypeHi) ? r3fc_pkg::crc24q_byte(crc_q, tail_q[0])
                                             : crc_q;
    tail_d[0] = tail_q[1];
    tail_d[1] = tail_q[2];
    tail_d[2] = b;

    count_d = (count_q != r3fc_pkg::CountMax) ? count_q + 11'd1 : count_q;
  end

  // Frame verdict from the state including this byte.
  always_comb begin
    expected = {tail_d[0], tail_d[1], tail_d[2]};
    ok = (count_d < r3fc_pkg::CountMax) && (count_d >= r3fc_pkg::MinFrameBytes) &&
         !hdr_bad_d && (len_d >= r3fc_pkg::MinLength) &&
         (({1'b0, len_d} + r3fc_pkg::FrameOverhead) == count_d) &&
         (crc_d == expected);
    result_o.frame_ok   = ok;
    result_o.msg_number = ok ? type_d : 12'h000;
    result_o.crc_value  = ok ? crc_d : 24'h000000;
  end

  // State update; the last byte clears the per-frame counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q     <= '0;
      count_q   <= '0;
      hdr_bad_q <= 1'b0;
      len_q     <= '0;
      type_q    <= '0;
      tail_q[0] <= '0;
      tail_q[1] <= '0;
      tail_q[2] <= '0;
    end else if (advance_i) begin
      len_q     <= len_d;
      type_q    <= type_d;
      tail_q[0] <= tail_d[0];
      tail_q[1] <= tail_d[1];
      tail_q[2] <= tail_d[2];
      if (item_i.last_byte) begin
        crc_q     <= '0;
        count_q   <= '0;
        hdr_bad_q <= 1'b0;
      end else begin
        crc_q     <= crc_d;
        count_q   <= count_d;
        hdr_bad_q <= hdr_bad_d;
      end
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/rtcm3_frame_checker.sv @@
// The result of a last byte is computed from the input register and loaded into the result
// register when that byte moves on.
// Throughput: one byte per cycle, including the last byte of back-to-back frames.
// A stalled result only holds back a last byte; other bytes keep flowing.
// Reset clears both stage valids and all frame state, including the delay line.
// Top level of the RTCM3 frame checker: input stage, frame core and result register.
`default_nettype none

module rtcm3_frame_checker (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire r3fc_pkg::in_t in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output r3fc_pkg::out_t     out_data_o
);

  logic           stage_valid;
  r3fc_pkg::in_t  stage_data;
  logic           out_free;
  logic           advance;
  r3fc_pkg::out_t result;
  logic           out_valid_q;
  r3fc_pkg::out_t out_data_q;

  // A byte moves on unless it is a last byte and the result slot is busy.
  assign out_free = !out_valid_q || !out_stall_i;
  assign advance  = stage_valid && (!stage_data.last_byte || out_free);

  r3fc_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .advance_i  (advance),
    .in_stall_o (in_stall_o),
    .valid_o    (stage_valid),
    .data_o     (stage_data)
  );

  r3fc_frame_core u_frame_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .item_i    (stage_data),
    .result_o  (result)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && stage_data.last_byte) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && stage_data.last_byte) begin
      out_data_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Upstream is held only by a last byte waiting on a stalled result.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (stage_valid && stage_data.last_byte && out_valid_o && out_stall_i))
    else $error("input stalled without a blocked result");

  // A last byte that moves on always shows up as a result next cycle.
  a_last_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && stage_data.last_byte) |=> out_valid_o)
    else $error("last byte produced no result");

  // A bad frame reports zero type and CRC.
  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.frame_ok) |->
      (out_data_o.msg_number == 12'h000 && out_data_o.crc_value == 24'h000000))
    else $error("bad frame carries nonzero fields");

  // A result that is taken with no new last byte behind it leaves the slot empty.
  a_result_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !(advance && stage_data.last_byte)) |=> !out_valid_o)
    else $error("result repeated");

endmodule

`default_nettype wire

@@ tb/tb_rtcm3_frame_checker.sv @@
// Self-checking testbench for the RTCM3 frame checker: framing rules, CRC-24Q and verdicts.
module tb_rtcm3_frame_checker;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ClkPeriod   = 10;
  localparam int QuietLimit  = 4000;
  localparam int DrainCycles = 8;
  localparam int RandomBytes = 600;

  logic          clk_i     = 1'b0;
  logic          rst_ni    = 1'b0;
  logic          in_valid  = 1'b0;
  r3fc_pkg::in_t in_data   = '0;
  logic          in_stall;
  logic          out_valid;
  logic          out_stall = 1'b0;
  r3fc_pkg::out_t out_data;

  // Idling rates in percent for the byte sender and the verdict receiver.
  int send_idle_pct = 0;
  int stall_pct     = 0;

  // Predicted frame state, mirroring the block after reset.
  logic [23:0] body_crc   = '0;
  logic [10:0] byte_cnt   = '0;
  logic [23:0] tail_bytes = '0;
  logic [9:0]  len_field  = '0;
  logic [11:0] type_field = '0;
  logic        hdr_bad    = 1'b0;

  r3fc_pkg::out_t verdict_q[$];
  logic [7:0]     frame_buf[$];

  int errors       = 0;
  int bytes_sent   = 0;
  int frames_sent  = 0;
  int good_seen    = 0;
  int bad_seen     = 0;
  int quiet_cycles = 0;

  rtcm3_frame_checker i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // CRC-24Q over one byte, MSB first, one feedback bit per step.
  function automatic logic [23:0] crc24q_fold(input logic [23:0] crc_in, input logic [7:0] data);
    logic [23:0] acc;
    logic        fb;
    acc = crc_in;
    for (int i = 7; i >= 0; i--) begin
      fb  = acc[23] ^ data[i];
      acc = {acc[22:0], 1'b0} ^ (fb ? r3fc_pkg::CrcPoly : 24'h000000);
    end
    return acc;
  endfunction

  // Advance the predicted frame state by one accepted byte; queue a verdict on the last byte.
  function automatic void fold_frame_byte(input r3fc_pkg::in_t req);
    logic           good;
    r3fc_pkg::out_t verdict;
    case (byte_cnt)
      r3fc_pkg::IdxPreamble: begin
        if (req.byte_value != r3fc_pkg::PreambleByte) hdr_bad = 1'b1;
      end
      r3fc_pkg::IdxLenHi: begin
        if ((req.byte_value & r3fc_pkg::ReservedMask) != 8'h00) hdr_bad = 1'b1;
        len_field[9:8] = req.byte_value[1:0];
      end
      r3fc_pkg::IdxLenLo:  len_field[7:0]   = req.byte_value;
      r3fc_pkg::IdxTypeHi: type_field[11:4] = req.byte_value;
      r3fc_pkg::IdxTypeLo: type_field[3:0]  = req.byte_value[7:4];
      default: ;
    endcase
    // The oldest byte of the three-byte delay line enters the CRC.
    if (byte_cnt >= r3fc_pkg::IdxTypeHi) body_crc = crc24q_fold(body_crc, tail_bytes[23:16]);
    tail_bytes = {tail_bytes[15:0], req.byte_value};
    if (byte_cnt != r3fc_pkg::CountMax) byte_cnt = byte_cnt + 11'd1;
    if (req.last_byte) begin
      good = (byte_cnt != r3fc_pkg::CountMax) && (byte_cnt >= r3fc_pkg::MinFrameBytes) &&
             !hdr_bad && (len_field >= r3fc_pkg::MinLength) &&
             (({1'b0, len_field} + r3fc_pkg::FrameOverhead) == byte_cnt) &&
             (body_crc == tail_bytes);
      verdict.frame_ok   = good;
      verdict.msg_number = good ? type_field : 12'h000;
      verdict.crc_value  = good ? body_crc : 24'h000000;
      verdict_q.push_back(verdict);
      body_crc = '0;
      byte_cnt = '0;
      hdr_bad  = 1'b0;
    end
  endfunction

  // Recompute the trailing CRC of the frame in the buffer.
  function automatic void reseal_frame();
    logic [23:0] c;
    int n;
    c = '0;
    n = frame_buf.size();
    for (int i = 0; i < n - 3; i++) c = crc24q_fold(c, frame_buf[i]);
    frame_buf[n - 3] = c[23:16];
    frame_buf[n - 2] = c[15:8];
    frame_buf[n - 1] = c[7:0];
  endfunction

  // Build a well-formed frame with a random payload that starts with the message type.
  function automatic void build_frame(input logic [9:0] plen, input logic [11:0] mtype);
    logic [7:0] b;
    frame_buf.delete();
    frame_buf.push_back(r3fc_pkg::PreambleByte);
    frame_buf.push_back({6'b000000, plen[9:8]});
    frame_buf.push_back(plen[7:0]);
    for (int i = 0; i < plen; i++) begin
      b = 8'($urandom_range(255));
      if (i == 0) b = mtype[11:4];
      if (i == 1) b[7:4] = mtype[3:0];
      frame_buf.push_back(b);
    end
    repeat (3) frame_buf.push_back(8'h00);
    reseal_frame();
  endfunction

  // Fill the buffer with random bytes, sometimes starting with a preamble.
  function automatic void build_noise(input int n);
    frame_buf.delete();
    for (int i = 0; i < n; i++) frame_buf.push_back(8'($urandom_range(255)));
    if ($urandom_range(1) == 1) frame_buf[0] = r3fc_pkg::PreambleByte;
  endfunction

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    stall_pct     = recv_pct;
  endtask

  // Offer one byte request and wait until it is taken.
  task automatic send_byte(input logic [7:0] value, input logic last);
    r3fc_pkg::in_t req;
    req.byte_value = value;
    req.last_byte  = last;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    fold_frame_byte(req);
    bytes_sent++;
  endtask

  task automatic send_frame();
    int n;
    n = frame_buf.size();
    for (int i = 0; i < n; i++) send_byte(frame_buf[i], i == n - 1);
    frames_sent++;
  endtask

  // Extremes of the header fields and each framing rule on its own.
  task automatic test_directed_frames();
    set_idling(0, 0);
    build_frame(10'd2, 12'h000);
    send_frame();
    build_frame(10'd3, 12'hFFF);
    send_frame();
    build_frame(10'd2, 12'h3A5);
    frame_buf[0] = 8'h00;
    reseal_frame();
    send_frame();
    build_frame(10'd2, 12'h5C3);
    frame_buf[1] = frame_buf[1] | r3fc_pkg::ReservedMask;
    reseal_frame();
    send_frame();
    // Length fields below the minimum give frames of six and seven bytes.
    build_frame(10'd1, 12'h111);
    send_frame();
    build_frame(10'd0, 12'h222);
    send_frame();
    build_frame(10'd5, 12'h333);
    frame_buf[2] = 8'd6;
    reseal_frame();
    send_frame();
    build_frame(10'd6, 12'h444);
    frame_buf[frame_buf.size() - 1] ^= 8'h01;
    send_frame();
    // A lone preamble and a frame that ends before its header is complete.
    send_byte(r3fc_pkg::PreambleByte, 1'b1);
    frames_sent++;
    build_frame(10'd4, 12'hABC);
    while (frame_buf.size() > 4) void'(frame_buf.pop_back());
    send_frame();
  endtask

  // Headers broken in one field, or left intact, with valid CRCs while the sender pauses often.
  task automatic test_header_faults();
    int kind;
    set_idling(51, 0);
    repeat (16) begin
      build_frame(10'($urandom_range(2, 16)), 12'($urandom_range(4095)));
      kind = $urandom_range(3);
      case (kind)
        0: frame_buf[0] = r3fc_pkg::PreambleByte ^ 8'($urandom_range(1, 255));
        1: frame_buf[1] = frame_buf[1] | 8'($urandom_range(1, 63) << 2);
        2: frame_buf[2] = frame_buf[2] ^ 8'($urandom_range(1, 255));
        default: ;
      endcase
      reseal_frame();
      send_frame();
    end
  endtask

  // Frames below eight bytes, some of them single bytes back to back, against a slow receiver.
  task automatic test_short_frames();
    int n;
    set_idling(0, 51);
    repeat (40) begin
      n = $urandom_range(1, 7);
      if ($urandom_range(1) == 1) begin
        build_frame(10'($urandom_range(0, 8)), 12'($urandom_range(4095)));
        while (frame_buf.size() > n) void'(frame_buf.pop_back());
      end else begin
        build_noise(n);
      end
      send_frame();
    end
  endtask

  // A long frame whose length field uses its upper bits, then a minimum frame right behind.
  task automatic test_long_frames();
    set_idling(9, 9);
    build_frame(10'd300, 12'($urandom_range(4095)));
    send_frame();
    build_frame(10'd2, 12'h123);
    send_frame();
  endtask

  // Mostly well-formed frames with random content, plus corrupted ones and noise.
  task automatic test_random_frames();
    int start;
    int pick;
    int idx;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: set_idling(0, 0);
        1: set_idling(51, 0);
        2: set_idling(0, 51);
        default: set_idling(9, 9);
      endcase
      start = bytes_sent;
      while (bytes_sent - start < RandomBytes / 4) begin
        if ($urandom_range(99) < 95) begin
          build_frame(10'($urandom_range(2, 24)), 12'($urandom_range(4095)));
        end else begin
          build_frame(10'($urandom_range(25, 300)), 12'($urandom_range(4095)));
        end
        pick = $urandom_range(99);
        if (pick >= 90) begin
          build_noise($urandom_range(1, 12));
        end else if (pick >= 83) begin
          repeat ($urandom_range(1, 4)) frame_buf.push_back(8'($urandom_range(255)));
        end else if (pick >= 75) begin
          repeat ($urandom_range(1, frame_buf.size() - 1)) void'(frame_buf.pop_back());
        end else if (pick >= 65) begin
          idx = $urandom_range(frame_buf.size() - 1);
          frame_buf[idx][$urandom_range(7)] ^= 1'b1;
        end
        send_frame();
      end
    end
  endtask

  // Compare each accepted verdict with the oldest prediction; draw the next stall.
  always @(posedge clk_i) begin : verdict_check
    r3fc_pkg::out_t want;
    if (out_valid && !out_stall) begin
      if (verdict_q.size() == 0) begin
        $error("verdict with no frame pending: %p", out_data);
        errors++;
      end else begin
        want = verdict_q.pop_front();
        if (out_data.frame_ok !== want.frame_ok) begin
          $error("frame_ok: expected %0h, actual %0h", want.frame_ok, out_data.frame_ok);
          errors++;
        end
        if (out_data.msg_number !== want.msg_number) begin
          $error("msg_number: expected %0h, actual %0h", want.msg_number,
                 out_data.msg_number);
          errors++;
        end
        if (out_data.crc_value !== want.crc_value) begin
          $error("crc_value: expected %06h, actual %06h", want.crc_value, out_data.crc_value);
          errors++;
        end
        if (want.frame_ok) good_seen++;
        else bad_seen++;
      end
    end
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Stop the run when no request moves on either side for too long.
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QuietLimit) begin
      $display("Timeout: no request accepted for %0d cycles", QuietLimit);
      $display("** rtcm3_frame_checker: FAILED **");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_frames();
    test_header_faults();
    test_short_frames();
    test_long_frames();
    test_random_frames();
    in_valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (verdict_q.size() != 0) begin
      $error("%0d verdicts never arrived", verdict_q.size());
      errors++;
    end
    $display("Checked %0d verdicts (%0d good, %0d bad) over %0d frames and %0d bytes.",
             good_seen + bad_seen, good_seen, bad_seen, frames_sent, bytes_sent);
    $display("Covered header faults, short and long frames, noise and four idling mixes.");
    if (errors == 0) begin
      $display("** rtcm3_frame_checker: PASSED **");
    end else begin
      $display("** rtcm3_frame_checker: FAILED **");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/r3fc_pkg.sv
hw/rtl/r3fc_in_stage.sv
hw/rtl/r3fc_frame_core.sv
hw/rtl/rtcm3_frame_checker.sv
tb/tb_rtcm3_frame_checker.sv
